// ===== sv/smt_pkg.sv =====
// Shared types and constants of the sparse matrix transpose block.
// No dependencies; every other file of the block but smt_ram imports this package.
`default_nettype none
package smt_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int VALUE_BITS_DEF  = 64;
	localparam int MAX_COLS        = 256;
	localparam int COL_W           = 8;
	localparam int ROW_W           = 8;
	localparam int IDX_W           = 16;
	localparam int VAL_W           = 64;
	localparam int NCOLS_W         = 9;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int KIND_W          = 2;
	localparam int QDEPTH          = 2;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET = 1'd1;

	localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 9'd256;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_PRE_RD,
		ST_PRE_WR,
		ST_SC_SRC,
		ST_SC_CNT,
		ST_SC_WR,
		ST_RD_ISSUE,
		ST_RD_EMIT
	} back_state_t;

	typedef struct packed {
		logic scattered;
		logic rd_over;
	} back_stat_t;

endpackage
`default_nettype wire

// ===== sv/sparse_matrix_transpose_top.sv =====
// Sparse matrix transpose by counting sort. Each load in the engine reads the
// column count, then writes the count and the entry; a read after the first
// passes through issue, memory read and the result register. The first read
// after loading runs a prefix sum over the 256 column counts, a count read and
// a count write per column, then scatters the stored entries with a source read,
// a column count read and an entry and count write per entry. A two-word command
// queue lets the input side keep accepting while the engine works, and a result
// register lets it run while a result waits to be popped.
// Depends on smt_pkg, smt_front, smt_cmd_fifo, smt_back.
`default_nettype none
module sparse_matrix_transpose_top #(
	parameter int MAX_ENTRIES = smt_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_BITS  = smt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [smt_pkg::KIND_W-1:0]     kind,
	input  wire logic [smt_pkg::ROW_W-1:0]      row,
	input  wire logic [smt_pkg::IDX_W-1:0]      col_index,
	input  wire logic [smt_pkg::VAL_W-1:0]      value,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [smt_pkg::ROW_W-1:0]           out_row,
	output logic [smt_pkg::COL_W-1:0]           out_col,
	output logic [smt_pkg::VAL_W-1:0]           out_value,
	output logic                                last,
	output logic                                none_left,
	output logic                                overflow,
	input  wire logic                           cfg_we,
	input  wire logic [smt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [smt_pkg::CFG_W-1:0]      cfg_wdata
);
	import smt_pkg::*;

	cmd_t       f_cmd, q_head;
	logic       f_push, q_full, q_empty, q_pop;
	back_stat_t stat;

	smt_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.row(row), .col_index(col_index), .value(value), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .q_push(f_push),
		.q_cmd(f_cmd), .q_full(q_full)
	);

	smt_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(f_push), .wdata(f_cmd), .q_full(q_full),
		.rd(q_pop), .rdata(q_head), .q_empty(q_empty)
	);

	smt_back #(.MAX_ENTRIES(MAX_ENTRIES), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_head(q_head),
		.q_pop(q_pop), .empty(empty), .pop(pop), .out_row(out_row),
		.out_col(out_col), .out_value(out_value), .last(last),
		.none_left(none_left), .overflow(overflow), .stat(stat)
	);

`ifndef ASSERT_OFF
	// read position never passes the entry total
	a_rdpos: assert property (@(posedge clk) disable iff (!arst_n) !stat.rd_over)
		else $error("read position beyond entry total");

	// an exhausted result carries no entry
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && none_left) |-> (!last && out_row == '0 && out_col == '0 &&
		out_value == '0))
		else $error("none_left result with entry fields set");
`endif
endmodule
`default_nettype wire

// ===== sv/smt_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/smt_front.sv =====
// Front end: configuration registers, input word classification, row drop tracking.
// Depends on smt_pkg.
`default_nettype none
module smt_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [smt_pkg::KIND_W-1:0]     kind,
	input  wire logic [smt_pkg::ROW_W-1:0]      row,
	input  wire logic [smt_pkg::IDX_W-1:0]      col_index,
	input  wire logic [smt_pkg::VAL_W-1:0]      value,
	input  wire logic                           cfg_we,
	input  wire logic [smt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [smt_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                                q_push,
	output smt_pkg::cmd_t                       q_cmd,
	input  wire logic                           q_full
);
	import smt_pkg::*;

	logic [NCOLS_W-1:0] num_cols_q;
	logic [IDX_W-1:0]   col_offset_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic               drop_q;
	logic               rd_seen_q;

	logic [NCOLS_W-1:0] cols;
	logic               acc;
	logic               dropping;
	logic               below;
	logic               past;
	logic [IDX_W-1:0]   c;
	logic               is_load;

	// clamp column count and classify the incoming word
	always_comb begin
		if (num_cols_q == '0) begin
			cols = NCOLS_W'(1);
		end else if (num_cols_q > NCOLS_W'(MAX_COLS)) begin
			cols = NCOLS_W'(MAX_COLS);
		end else begin
			cols = num_cols_q;
		end
		acc      = push && !q_full;
		dropping = (row == cur_row_q) && drop_q;
		below    = col_index < col_offset_q;
		c        = col_index - col_offset_q;
		past     = IDX_W'(cols) <= c;
		is_load  = (kind == KIND_LOAD) && !rd_seen_q;
		q_push   = acc && ((is_load && !dropping && !below && !past) ||
			kind == KIND_READ || kind == KIND_CLEAR);
		q_cmd.row   = row;
		q_cmd.col   = c[COL_W-1:0];
		q_cmd.value = value;
		case (kind)
			KIND_READ:  q_cmd.op = OP_READ;
			KIND_CLEAR: q_cmd.op = OP_CLEAR;
			default:    q_cmd.op = OP_STORE;
		endcase
	end

	assign full = q_full;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q   <= NUM_COLS_RST;
			col_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_COLS:   num_cols_q   <= cfg_wdata[NCOLS_W-1:0];
				REG_COL_OFFSET: col_offset_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// track current row, row dropping and whether reading began
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			drop_q    <= 1'b0;
			rd_seen_q <= 1'b0;
		end else if (acc) begin
			if (is_load) begin
				cur_row_q <= row;
				drop_q    <= dropping || (!below && past);
			end else if (kind == KIND_READ) begin
				rd_seen_q <= 1'b1;
			end else if (kind == KIND_CLEAR) begin
				cur_row_q <= '0;
				drop_q    <= 1'b0;
				rd_seen_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/smt_cmd_fifo.sv =====
// Short command queue between the front end and the transpose engine.
// Depends on smt_pkg.
`default_nettype none
module smt_cmd_fifo (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire smt_pkg::cmd_t wdata,
	output logic         q_full,
	input  wire logic    rd,
	output smt_pkg::cmd_t rdata,
	output logic         q_empty
);
	import smt_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int NW = $clog2(QDEPTH + 1);

	cmd_t          ent_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [NW-1:0] cnt_q;

	assign q_full  = cnt_q == NW'(QDEPTH);
	assign q_empty = cnt_q == '0;
	assign rdata   = ent_q[rp_q];

	// store words
	always_ff @(posedge clk) begin
		if (wr && !q_full) begin
			ent_q[wp_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !q_full) begin
				wp_q <= wp_q + PW'(1);
			end
			if (rd && !q_empty) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(wr && !q_full) - NW'(rd && !q_empty);
		end
	end
endmodule
`default_nettype wire

// ===== sv/smt_back.sv =====
// Transpose engine: entry stores, column counts, prefix sum, scatter, result register.
// Depends on smt_pkg and smt_ram.
`default_nettype none
module smt_back #(
	parameter int MAX_ENTRIES = smt_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_BITS  = smt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_empty,
	input  wire smt_pkg::cmd_t             q_head,
	output logic                           q_pop,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [smt_pkg::ROW_W-1:0]      out_row,
	output logic [smt_pkg::COL_W-1:0]      out_col,
	output logic [smt_pkg::VAL_W-1:0]      out_value,
	output logic                           last,
	output logic                           none_left,
	output logic                           overflow,
	output smt_pkg::back_stat_t            stat
);
	import smt_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = ROW_W + COL_W + VALUE_BITS;
	localparam int CAW = $clog2(MAX_COLS);

	back_state_t          state_q, state_d;
	cmd_t                 cmd_q;
	logic [CW-1:0]        total_q;
	logic [CW-1:0]        rdpos_q;
	logic [CW-1:0]        scat_q;
	logic [CW-1:0]        sum_q;
	logic [CAW-1:0]       pidx_q;
	logic                 scattered_q;
	logic                 ovf_q;
	logic [MAX_COLS-1:0]  valid_q;
	logic                 cnt_vld_s1;
	logic                 out_vld_q;

	logic                 full_st;
	logic                 out_free;
	logic                 rd_none;
	logic [CW-1:0]        n_eff;

	logic                 cnt_we;
	logic [CAW-1:0]       cnt_waddr, cnt_raddr;
	logic [CW-1:0]        cnt_wdata, cnt_rdata;
	logic                 src_we;
	logic [SW-1:0]        src_wdata, src_rdata;
	logic                 dst_we;
	logic [SW-1:0]        dst_rdata;
	logic [COL_W-1:0]     src_col;
	logic [COL_W-1:0]     dst_col;
	logic [ROW_W-1:0]     dst_row;
	logic [VALUE_BITS-1:0] dst_val;

	assign src_col  = src_rdata[VALUE_BITS +: COL_W];
	assign dst_val  = dst_rdata[VALUE_BITS-1:0];
	assign dst_col  = dst_rdata[VALUE_BITS +: COL_W];
	assign dst_row  = dst_rdata[VALUE_BITS+COL_W +: ROW_W];
	assign full_st  = total_q == CW'(MAX_ENTRIES);
	assign out_free = !out_vld_q || pop;
	assign rd_none  = rdpos_q >= total_q;
	assign n_eff    = cnt_vld_s1 ? cnt_rdata : '0;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign empty    = !out_vld_q;
	assign stat.scattered = scattered_q;
	assign stat.rd_over   = rdpos_q > total_q;

	smt_ram #(.WIDTH(CW), .DEPTH(MAX_COLS)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	smt_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_src_ram (
		.clk(clk), .we(src_we), .waddr(total_q[AW-1:0]), .wdata(src_wdata),
		.raddr(scat_q[AW-1:0]), .rdata(src_rdata)
	);

	smt_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_dst_ram (
		.clk(clk), .we(dst_we), .waddr(cnt_rdata[AW-1:0]), .wdata(src_rdata),
		.raddr(rdpos_q[AW-1:0]), .rdata(dst_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_head.op)
						OP_STORE: state_d = full_st ? ST_IDLE : ST_STORE;
						OP_READ:  state_d = scattered_q ? ST_RD_ISSUE : ST_PRE_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_STORE:  state_d = ST_IDLE;
			ST_PRE_RD: state_d = ST_PRE_WR;
			ST_PRE_WR: state_d = (pidx_q == CAW'(MAX_COLS - 1)) ? ST_SC_SRC : ST_PRE_RD;
			ST_SC_SRC: state_d = (scat_q == total_q) ? ST_RD_ISSUE : ST_SC_CNT;
			ST_SC_CNT: state_d = ST_SC_WR;
			ST_SC_WR:  state_d = ST_SC_SRC;
			ST_RD_ISSUE: state_d = out_free ? ST_RD_EMIT : ST_RD_ISSUE;
			ST_RD_EMIT:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = pidx_q;
		cnt_wdata = sum_q;
		src_we    = 1'b0;
		src_wdata = {cmd_q.row, cmd_q.col, cmd_q.value[VALUE_BITS-1:0]};
		dst_we    = 1'b0;
		case (state_q)
			ST_IDLE:   cnt_raddr = q_head.col;
			ST_SC_CNT: cnt_raddr = src_col;
			default:   cnt_raddr = pidx_q;
		endcase
		case (state_q)
			ST_STORE: begin
				cnt_we    = 1'b1;
				cnt_waddr = cmd_q.col;
				cnt_wdata = n_eff + CW'(1);
				src_we    = 1'b1;
			end
			ST_PRE_WR: begin
				cnt_we = 1'b1;
			end
			ST_SC_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = src_col;
				cnt_wdata = cnt_rdata + CW'(1);
				dst_we    = 1'b1;
			end
			default: ;
		endcase
	end

	// hold the popped command and register the count valid bit
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		cnt_vld_s1 <= valid_q[cnt_raddr];
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			rdpos_q     <= '0;
			scat_q      <= '0;
			sum_q       <= '0;
			pidx_q      <= '0;
			scattered_q <= 1'b0;
			ovf_q       <= 1'b0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_head.op)
							OP_STORE: begin
								if (full_st) begin
									ovf_q <= 1'b1;
								end
							end
							OP_READ: begin
								pidx_q <= '0;
								sum_q  <= '0;
								scat_q <= '0;
							end
							OP_CLEAR: begin
								total_q     <= '0;
								rdpos_q     <= '0;
								scattered_q <= 1'b0;
								ovf_q       <= 1'b0;
								valid_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_STORE: begin
					total_q          <= total_q + CW'(1);
					valid_q[cmd_q.col] <= 1'b1;
				end
				ST_PRE_WR: begin
					valid_q[pidx_q] <= 1'b1;
					sum_q           <= sum_q + n_eff;
					pidx_q          <= pidx_q + CAW'(1);
				end
				ST_SC_SRC: begin
					if (scat_q == total_q) begin
						scattered_q <= 1'b1;
					end
				end
				ST_SC_WR: begin
					scat_q <= scat_q + CW'(1);
				end
				ST_RD_EMIT: begin
					if (!rd_none) begin
						rdpos_q <= rdpos_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RD_EMIT) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_EMIT) begin
			overflow  <= ovf_q;
			none_left <= rd_none;
			if (rd_none) begin
				out_row   <= '0;
				out_col   <= '0;
				out_value <= '0;
				last      <= 1'b0;
			end else begin
				out_row   <= dst_col;
				out_col   <= dst_row;
				out_value <= VAL_W'($signed(dst_val));
				last      <= (rdpos_q + CW'(1)) == total_q;
			end
		end
	end
endmodule
`default_nettype wire
